>>> sv/dur_pkg.sv
// shared types and constants for the daily usage ring with window sum
// no dependencies; imported by dur_alu, the top level and the bench
`default_nettype none

package dur_pkg;

    localparam int RING_DAYS = 365;
    localparam int DAY_W     = 17;
    localparam int WIN_W     = 9;
    localparam int CNT_W     = 32;
    localparam int SLOT_W    = $clog2(RING_DAYS);
    localparam int LEFT_W    = $clog2(RING_DAYS + 1);

    // day / RING_DAYS as (day * RECIP_M) >> RECIP_SH, exact over the whole day range
    localparam int RECIP_SH  = DAY_W + SLOT_W;
    localparam int RECIP_W   = DAY_W + 1;
    localparam int Q_W       = DAY_W - SLOT_W + 1;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(RING_DAYS) - 64'd1) / 64'(RING_DAYS));

    localparam logic [DAY_W-1:0] MIN_VALID_RST = DAY_W'(18262);

    typedef struct packed {
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
        logic             cin;
    } t_alu_req;

endpackage

`default_nettype wire

>>> sv/daily_usage_ring_with_window_sum_unit.sv
// daily usage ring with window sum: sequencer around one shared adder and a slot ram
// steps: an invalid clock goes straight to output; a valid one runs modulo, roll (clearing
//   no slot, the day gap or all 365), count, yesterday read if any, then window sum
// one item at a time: input is ready only in idle, and a result waits out any output stall
// reset: synchronous active low, then a pass clearing all 365 slots, no item accepted
// depends on dur_pkg, dur_alu, dur_ram
`default_nettype none

module daily_usage_ring_with_window_sum_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [dur_pkg::DAY_W-1:0]   i_cfg_data,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [31:0]                 s_axis_tdata,  // day_number, window_days
    input  wire logic                        s_axis_tuser,  // action
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [95:0]                 m_axis_tdata,  // today, yesterday, window sum
    output logic                             m_axis_tuser   // clock_valid
);
    import dur_pkg::*;

    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_MOD      = 4'd2;
    localparam logic [3:0] S_ROLL     = 4'd3;
    localparam logic [3:0] S_RD_TODAY = 4'd4;
    localparam logic [3:0] S_WR_TODAY = 4'd5;
    localparam logic [3:0] S_RD_YEST  = 4'd6;
    localparam logic [3:0] S_GET_YEST = 4'd7;
    localparam logic [3:0] S_SUM      = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;
    localparam logic [3:0] S_MOD_SUB  = 4'd10;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DAYS - 1);
    localparam logic [LEFT_W-1:0] RING_LEFT = LEFT_W'(RING_DAYS);
    localparam logic [DAY_W:0]    RING_EXT  = (DAY_W + 1)'(RING_DAYS);

    logic [3:0]        r_state, n_state;
    logic              r_init, n_init;
    logic [DAY_W-1:0]  r_min, n_min;
    logic [DAY_W-1:0]  r_day, n_day;
    logic              r_act, n_act;
    logic [WIN_W-1:0]  r_win_in, n_win_in;
    logic              r_valid, n_valid;
    logic              r_had, n_had;
    logic              r_last_vld, n_last_vld;
    logic [DAY_W-1:0]  r_last, n_last;
    logic [Q_W-1:0]    r_quot, n_quot;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_addr, n_addr;
    logic [LEFT_W-1:0] r_left, n_left;
    logic [LEFT_W-1:0] r_win, n_win;
    logic              r_pend, n_pend;
    logic [CNT_W-1:0]  r_today, n_today;
    logic [CNT_W-1:0]  r_yest, n_yest;
    logic [CNT_W-1:0]  r_acc, n_acc;
    logic              r_m_valid, n_m_valid;
    logic              r_o_vld, n_o_vld;
    logic [95:0]       r_o_data, n_o_data;

    t_alu_req          alu_req;
    logic [CNT_W:0]    alu_sum;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
    logic [CNT_W-1:0]  ram_rdata;

    logic                     s_accept;
    logic [DAY_W+RECIP_W-1:0] recip_prod;
    logic [DAY_W-1:0]         quot_mul;
    logic [DAY_W-1:0]         gap;
    logic [DAY_W:0]           day_p1;
    logic [DAY_W:0]           win_ext;
    logic [DAY_W:0]           win_clamp;
    logic [SLOT_W-1:0]        addr_dec;
    logic [SLOT_W-1:0]        yest_slot;

    dur_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    dur_ram #(
        .WIDTH (CNT_W),
        .DEPTH (RING_DAYS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_o_vld;
    assign m_axis_tdata  = r_o_data;

    assign recip_prod = (DAY_W + RECIP_W)'(r_day) * (DAY_W + RECIP_W)'(RECIP_M);
    assign quot_mul   = DAY_W'(r_quot) * DAY_W'(RING_DAYS);
    assign gap        = r_day - r_last;
    assign day_p1     = {1'b0, r_day} + (DAY_W + 1)'(1);
    assign win_ext    = {{(DAY_W + 1 - WIN_W){1'b0}}, r_win_in};
    assign addr_dec   = (r_addr == '0) ? LAST_SLOT : r_addr - SLOT_W'(1);
    assign yest_slot  = (r_slot == '0) ? LAST_SLOT : r_slot - SLOT_W'(1);

    always_comb begin
        win_clamp = win_ext;
        if (win_clamp > RING_EXT) begin
            win_clamp = RING_EXT;
        end
        if (win_clamp > day_p1) begin
            win_clamp = day_p1;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_init     = r_init;
        n_min      = r_min;
        n_day      = r_day;
        n_act      = r_act;
        n_win_in   = r_win_in;
        n_valid    = r_valid;
        n_had      = r_had;
        n_last_vld = r_last_vld;
        n_last     = r_last;
        n_quot     = r_quot;
        n_slot     = r_slot;
        n_addr     = r_addr;
        n_left     = r_left;
        n_win      = r_win;
        n_pend     = r_pend;
        n_today    = r_today;
        n_yest     = r_yest;
        n_acc      = r_acc;
        n_m_valid  = r_m_valid;
        n_o_vld    = r_o_vld;
        n_o_data   = r_o_data;

        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.cin = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_addr;

        if (i_cfg_valid) begin
            n_min = i_cfg_data;
        end
        if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
                n_addr = addr_dec;
                n_left = r_left - LEFT_W'(1);
                if (r_left == LEFT_W'(1)) begin
                    n_state = r_init ? S_IDLE : S_RD_TODAY;
                    n_init  = 1'b0;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_day    = s_axis_tdata[DAY_W-1:0];
                    n_win_in = s_axis_tdata[DAY_W+WIN_W-1:DAY_W];
                    n_act    = s_axis_tuser;
                    n_valid  = (s_axis_tdata[DAY_W-1:0] >= r_min);
                    n_today  = '0;
                    n_yest   = '0;
                    n_acc    = '0;
                    n_state  = (s_axis_tdata[DAY_W-1:0] >= r_min) ? S_MOD : S_OUT;
                end
            end
            S_MOD: begin
                // quotient by 365 through a reciprocal multiply
                n_quot  = recip_prod[RECIP_SH +: Q_W];
                n_state = S_MOD_SUB;
            end
            S_MOD_SUB: begin
                // slot = day - quotient * 365 on the shared adder
                alu_req.a   = CNT_W'(r_day);
                alu_req.b   = ~CNT_W'(quot_mul);
                alu_req.cin = 1'b1;
                n_slot  = alu_sum[SLOT_W-1:0];
                n_state = S_ROLL;
            end
            S_ROLL: begin
                n_had      = r_last_vld;
                n_last_vld = 1'b1;
                n_last     = r_day;
                n_win      = LEFT_W'(win_clamp);
                if (r_last_vld && r_day == r_last) begin
                    n_state = S_RD_TODAY;
                end else if (!r_last_vld || r_day < r_last ||
                             {1'b0, gap} >= RING_EXT) begin
                    n_addr  = LAST_SLOT;
                    n_left  = RING_LEFT;
                    n_state = S_CLR;
                end else begin
                    // zero the passed days, walking back from today
                    n_addr  = r_slot;
                    n_left  = LEFT_W'(gap);
                    n_state = S_CLR;
                end
            end
            S_RD_TODAY: begin
                ram_re    = 1'b1;
                ram_raddr = r_slot;
                n_state   = S_WR_TODAY;
            end
            S_WR_TODAY: begin
                alu_req.a   = ram_rdata;
                alu_req.cin = r_act;
                ram_we      = r_act;
                ram_waddr   = r_slot;
                ram_wdata   = alu_sum[CNT_W-1:0];
                n_today     = alu_sum[CNT_W-1:0];
                n_state     = S_RD_YEST;
            end
            S_RD_YEST: begin
                if (r_had && r_day != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = yest_slot;
                    n_state   = S_GET_YEST;
                end else begin
                    n_yest  = '0;
                    n_addr  = r_slot;
                    n_left  = r_win;
                    n_pend  = 1'b0;
                    n_acc   = '0;
                    n_state = S_SUM;
                end
            end
            S_GET_YEST: begin
                n_yest  = ram_rdata;
                n_addr  = r_slot;
                n_left  = r_win;
                n_pend  = 1'b0;
                n_acc   = '0;
                n_state = S_SUM;
            end
            S_SUM: begin
                // each read is added in the cycle after it is issued
                alu_req.a = r_acc;
                alu_req.b = ram_rdata;
                if (r_pend) begin
                    n_acc = alu_sum[CNT_W-1:0];
                end
                if (r_left != '0) begin
                    ram_re = 1'b1;
                    n_addr = addr_dec;
                    n_left = r_left - LEFT_W'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_o_vld   = r_valid;
                    n_o_data  = {r_acc, r_yest, r_today};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_init     <= 1'b1;
            r_min      <= MIN_VALID_RST;
            r_last_vld <= 1'b0;
            r_last     <= '0;
            r_had      <= 1'b0;
            r_addr     <= LAST_SLOT;
            r_left     <= RING_LEFT;
            r_pend     <= 1'b0;
            r_m_valid  <= 1'b0;
            r_slot     <= '0;
        end else begin
            r_state    <= n_state;
            r_init     <= n_init;
            r_min      <= n_min;
            r_last_vld <= n_last_vld;
            r_last     <= n_last;
            r_had      <= n_had;
            r_addr     <= n_addr;
            r_left     <= n_left;
            r_pend     <= n_pend;
            r_m_valid  <= n_m_valid;
            r_slot     <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_day    <= n_day;
        r_act    <= n_act;
        r_win_in <= n_win_in;
        r_valid  <= n_valid;
        r_quot   <= n_quot;
        r_win    <= n_win;
        r_today  <= n_today;
        r_yest   <= n_yest;
        r_acc    <= n_acc;
        r_o_vld  <= n_o_vld;
        r_o_data <= n_o_data;
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !s_axis_tready)
        else $error("input accepted again right after a transfer");

    a_left_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= RING_LEFT)
        else $error("slot walk count beyond ring size");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST_SLOT && r_addr <= LAST_SLOT)
        else $error("slot index outside ring");

    a_write_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLR || r_state == S_WR_TODAY))
        else $error("ram write outside clear or count");

endmodule

`default_nettype wire

>>> sv/dur_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module dur_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 365
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/dur_alu.sv
// shared adder used for the modulo subtraction, the counter increment and the window sum
// depends on dur_pkg
`default_nettype none

module dur_alu (
    input  wire dur_pkg::t_alu_req          i_req,
    output logic [dur_pkg::CNT_W:0]         o_sum
);
    import dur_pkg::*;

    // carry out lands in the top bit
    assign o_sum = {1'b0, i_req.a} + {1'b0, i_req.b} + (CNT_W + 1)'(i_req.cin);

endmodule

`default_nettype wire

>>> bench/tb_daily_usage_ring_with_window_sum_unit.sv
// self-checking bench for the daily usage ring with window sum: directed table, then random days
// uses dur_pkg for widths and the reset value of the valid-day threshold
`timescale 1ns / 100ps

module tb_daily_usage_ring_with_window_sum_unit;
    import dur_pkg::*;

    localparam int MAX_DAY     = (1 << DAY_W) - 1;
    localparam int HOLD_CYCLES = 600;
    localparam int STALL_LIMIT = 8000;
    localparam int RAND_ITEMS  = 410;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] today;
        logic [CNT_W-1:0] yest;
        logic [CNT_W-1:0] wsum;
    } usage_rec_t;

    // for a config row the day field carries the new threshold
    typedef struct packed {
        row_kind_e        kind;
        logic [DAY_W-1:0] day;
        logic             act;
        logic [WIN_W-1:0] win;
        logic             typed;
        usage_rec_t       gold;
    } plan_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [DAY_W-1:0]      i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;   // day_number, window_days
    logic                  s_axis_tuser;   // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [95:0]           m_axis_tdata;   // today, yesterday, window sum
    logic                  m_axis_tuser;   // clock_valid

    // predictor state
    logic [CNT_W-1:0] slot_cnt [RING_DAYS];
    int               last_day;
    logic             day_seen;
    logic [DAY_W-1:0] min_day_reg;

    usage_rec_t usage_due_q [$];
    int         fail_cnt = 0;
    int         stall_cnt = 0;
    int         snd_gap_pct;
    int         rcv_gap_pct;
    logic       hold_req;
    int         cur_day;

    plan_row_t directed_plan [20] = '{
        // invalid clock at both ends of the range below the threshold
        '{ROW_ITEM, 17'd0,      1'b1, 9'd365, 1'b1, '{1'b0, 32'd0, 32'd0, 32'd0}},
        '{ROW_ITEM, 17'd18261,  1'b1, 9'd5,   1'b1, '{1'b0, 32'd0, 32'd0, 32'd0}},
        // first day with a zero window, then the same day again
        '{ROW_ITEM, 17'd18262,  1'b1, 9'd0,   1'b1, '{1'b1, 32'd1, 32'd0, 32'd0}},
        '{ROW_ITEM, 17'd18262,  1'b1, 9'd1,   1'b1, '{1'b1, 32'd2, 32'd0, 32'd2}},
        '{ROW_ITEM, 17'd18263,  1'b0, 9'd2,   1'b1, '{1'b1, 32'd0, 32'd2, 32'd2}},
        '{ROW_ITEM, 17'd18264,  1'b1, 9'd511, 1'b0, '0},
        // gap one short of the ring, then exactly the ring
        '{ROW_ITEM, 17'd18628,  1'b1, 9'd365, 1'b0, '0},
        '{ROW_ITEM, 17'd18993,  1'b1, 9'd3,   1'b1, '{1'b1, 32'd1, 32'd0, 32'd1}},
        // clock going backward
        '{ROW_ITEM, 17'd18900,  1'b1, 9'd10,  1'b1, '{1'b1, 32'd1, 32'd0, 32'd1}},
        '{ROW_ITEM, 17'd131071, 1'b1, 9'd511, 1'b1, '{1'b1, 32'd1, 32'd0, 32'd1}},
        '{ROW_ITEM, 17'd131071, 1'b0, 9'd256, 1'b1, '{1'b1, 32'd1, 32'd0, 32'd1}},
        '{ROW_CFG,  17'd0,      1'b0, 9'd0,   1'b0, '0},
        // day zero: no yesterday, window clamped to one day
        '{ROW_ITEM, 17'd0,      1'b1, 9'd5,   1'b1, '{1'b1, 32'd1, 32'd0, 32'd1}},
        '{ROW_ITEM, 17'd1,      1'b1, 9'd511, 1'b1, '{1'b1, 32'd1, 32'd1, 32'd2}},
        '{ROW_ITEM, 17'd1,      1'b1, 9'd2,   1'b1, '{1'b1, 32'd2, 32'd1, 32'd3}},
        '{ROW_ITEM, 17'd364,    1'b1, 9'd365, 1'b0, '0},
        '{ROW_CFG,  17'd131071, 1'b0, 9'd0,   1'b0, '0},
        '{ROW_ITEM, 17'd131070, 1'b1, 9'd1,   1'b1, '{1'b0, 32'd0, 32'd0, 32'd0}},
        '{ROW_ITEM, 17'd131071, 1'b1, 9'd170, 1'b0, '0},
        '{ROW_CFG,  17'd18262,  1'b0, 9'd0,   1'b0, '0}
    };

    daily_usage_ring_with_window_sum_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // rolls the ring to the given day, counts, and forms today/yesterday/window sum
    function automatic usage_rec_t roll_and_count(input logic [DAY_W-1:0] day,
                                                  input logic act,
                                                  input logic [WIN_W-1:0] win);
        usage_rec_t rec;
        logic       had_day;
        int         today;
        int         span;
        int         d;
        rec   = '0;
        today = int'(day);
        if (day < min_day_reg)
            return rec;
        had_day = day_seen;
        if (!(day_seen && today == last_day)) begin
            if (!day_seen || today < last_day || today - last_day >= RING_DAYS) begin
                for (d = 0; d < RING_DAYS; d++)
                    slot_cnt[d] = '0;
            end else begin
                for (d = last_day + 1; d <= today; d++)
                    slot_cnt[d % RING_DAYS] = '0;
            end
            last_day = today;
            day_seen = 1'b1;
        end
        if (act)
            slot_cnt[today % RING_DAYS] = slot_cnt[today % RING_DAYS] + 1'b1;
        rec.valid = 1'b1;
        rec.today = slot_cnt[today % RING_DAYS];
        if (had_day && today >= 1)
            rec.yest = slot_cnt[(today - 1) % RING_DAYS];
        span = int'(win);
        if (span > RING_DAYS)
            span = RING_DAYS;
        if (span > today + 1)
            span = today + 1;
        for (d = 0; d < span; d++)
            rec.wsum = rec.wsum + slot_cnt[(today - d) % RING_DAYS];
        return rec;
    endfunction

    // offers one item, with a random lead-in gap, and records what it must produce
    task automatic send_usage(input logic [DAY_W-1:0] day, input logic act,
                              input logic [WIN_W-1:0] win, input logic typed,
                              input usage_rec_t gold);
        usage_rec_t rec;
        while ($urandom_range(0, 99) < snd_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, win, day};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        rec = roll_and_count(day, act, win);
        usage_due_q.push_back(typed ? gold : rec);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (usage_due_q.size() != 0);
    endtask

    task automatic write_min_day(input logic [DAY_W-1:0] val);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        min_day_reg = val;
    endtask

    // mostly a clock walking forward a day at a time, with jumps, backsteps and noise
    task automatic send_random_usage();
        int          pick;
        int          day;
        logic [WIN_W-1:0] win;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            day = cur_day + $urandom_range(0, 1);
        else if (pick < 75)
            day = cur_day + $urandom_range(2, 20);
        else if (pick < 80)
            day = cur_day + $urandom_range(300, 400);
        else if (pick < 85)
            day = cur_day - $urandom_range(1, 50);
        else if (pick < 90 && min_day_reg != 0)
            day = $urandom_range(0, int'(min_day_reg) - 1);
        else
            day = $urandom_range(0, MAX_DAY);
        if (day > MAX_DAY)
            day = int'(min_day_reg) + $urandom_range(0, 50);
        if (day > MAX_DAY)
            day = MAX_DAY;
        if (day < 0)
            day = 0;
        if (day >= int'(min_day_reg))
            cur_day = day;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            win = WIN_W'($urandom_range(0, 8));
        else if (pick < 90)
            win = WIN_W'($urandom_range(9, 64));
        else
            win = WIN_W'($urandom_range(0, 511));
        send_usage(DAY_W'(day), $urandom_range(0, 99) < 80, win, 1'b0, '0);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rcv_gap_pct);
            end
        end
    end

    // result checker and stall watchdog
    always @(posedge i_clk) begin
        usage_rec_t want;
        usage_rec_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                    m_axis_tdata[95:64]};
            if (usage_due_q.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_cnt++;
            end else begin
                want = usage_due_q.pop_front();
                if (got.valid !== want.valid) begin
                    $error("clock_valid: expected %0d, got %0d", want.valid, got.valid);
                    fail_cnt++;
                end
                if (got.today !== want.today) begin
                    $error("today_seconds: expected %0d, got %0d", want.today, got.today);
                    fail_cnt++;
                end
                if (got.yest !== want.yest) begin
                    $error("yesterday_seconds: expected %0d, got %0d", want.yest, got.yest);
                    fail_cnt++;
                end
                if (got.wsum !== want.wsum) begin
                    $error("window_seconds: expected %0d, got %0d", want.wsum, got.wsum);
                    fail_cnt++;
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cnt = 0;
        end else begin
            stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", stall_cnt);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int i;
        int mode;
        logic ok;
        snd_gap_pct   = 32;
        rcv_gap_pct   = 75;
        min_day_reg   = MIN_VALID_RST;
        day_seen      = 1'b0;
        last_day      = 0;
        cur_day       = 0;
        for (i = 0; i < RING_DAYS; i++)
            slot_cnt[i] = '0;
        hold_req      <= 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_CFG)
                write_min_day(directed_plan[i].day);
            else
                send_usage(directed_plan[i].day, directed_plan[i].act, directed_plan[i].win,
                           directed_plan[i].typed, directed_plan[i].gold);
        end

        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    snd_gap_pct = 32;
                    rcv_gap_pct = 75;
                    write_min_day(MIN_VALID_RST);
                end
                1: begin
                    snd_gap_pct = 75;
                    rcv_gap_pct = 32;
                    write_min_day(DAY_W'($urandom_range(0, 120000)));
                end
                default: begin
                    snd_gap_pct = 0;
                    rcv_gap_pct = 0;
                    write_min_day('0);
                end
            endcase
            cur_day = int'(min_day_reg);
            for (i = 0; i < RAND_ITEMS; i++) begin
                // long result-side hold-off while items keep coming
                if (mode == 0 && i == 100)
                    hold_req <= 1'b1;
                // sender pauses until everything outstanding has come back
                if (mode == 1 && i == 200)
                    drain_results();
                send_random_usage();
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        ok = (fail_cnt == 0) && (usage_due_q.size() == 0);
        if (ok)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
